@@ design/unique_key_fifo_queue_unit_defines.svh @@
// assertion macros shared by the queue modules
// every macro samples on clk and is off while rst is high
`ifndef UNIQUE_KEY_FIFO_QUEUE_UNIT_DEFINES_SVH
`define UNIQUE_KEY_FIFO_QUEUE_UNIT_DEFINES_SVH

// property that must hold at every edge
`define UKFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must be followed by a result in the next cycle
`define UKFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ukfq_pkg.sv @@
package ukfq_pkg;

  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 7;
  localparam int TOTAL_W = 7;

  // operation codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_READ   = 2'd2;
  localparam mode_t MODE_NOP    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic [KEY_W-1:0]         key;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [KEY_W-1:0]         out_key;
    logic signed [VAL_W-1:0]  out_value;
    logic [TOTAL_W-1:0]       entry_total;
    logic                     head_valid;
    logic [KEY_W-1:0]         head_key;
    logic signed [VAL_W-1:0]  head_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    status_we;
    status_t status_code;
    logic    scan_start;
    logic    scan_run;
    logic    rd_item;
    logic    capture_result;
    logic    pop;
    logic    push;
    logic    rd_head;
    logic    capture_head;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  pos_bad;
    logic  scan_done;
    logic  scan_hit;
  } dp_sts_t;

endpackage

@@ design/ukfq_ctrl.sv @@
`include "unique_key_fifo_queue_unit_defines.svh"

module ukfq_ctrl
  import ukfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_OP        = 7'b0000010,
    S_SCAN      = 7'b0000100,
    S_FETCH     = 7'b0001000,
    S_HEAD_RD   = 7'b0010000,
    S_HEAD_WAIT = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_OP;
        end
      end
      S_OP: begin
        unique case (sts.mode)
          MODE_INSERT: begin
            if (sts.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_HEAD_RD;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          MODE_REMOVE: begin
            if (sts.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_HEAD_RD;
            end else begin
              cmd.rd_item = 1'b1;
              state_next  = S_FETCH;
            end
          end
          MODE_READ: begin
            if (sts.pos_bad) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_RANGE;
              state_next      = S_HEAD_RD;
            end else begin
              cmd.rd_item = 1'b1;
              state_next  = S_FETCH;
            end
          end
          default: begin
            state_next = S_HEAD_RD;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_DUP;
          state_next      = S_HEAD_RD;
        end else if (sts.scan_done) begin
          cmd.push   = 1'b1;
          state_next = S_HEAD_RD;
        end
      end
      S_FETCH: begin
        cmd.capture_result = 1'b1;
        cmd.pop            = (sts.mode == MODE_REMOVE);
        state_next         = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        cmd.capture_head = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_DONE);

  `UKFQ_ASSERT(a_one_item_in_flight, !rsp_valid || req_stall, "input taken while a result waits")
  `UKFQ_ASSERT(a_scan_for_insert, !cmd.scan_run || sts.mode == MODE_INSERT, "scan outside insert")
  `UKFQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

endmodule

@@ design/ukfq_datapath.sv @@
`include "unique_key_fifo_queue_unit_defines.svh"

module ukfq_datapath
  import ukfq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output rsp_t      rsp
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int PW      = (CW > POS_W) ? CW : POS_W;
  localparam int ENTRY_W = KEY_W + VAL_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);

  // circular add of an offset below DEPTH to a slot
  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [AW-1:0] offs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;

  req_t          item;
  logic [AW-1:0] head_idx;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          cmp_pending;
  logic          hit;
  rsp_t          result;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic [AW-1:0] item_offs;
  logic [AW-1:0] item_slot;
  logic [AW-1:0] scan_slot;
  logic [AW-1:0] tail_slot;
  logic          scan_issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;

  assign pos_ext   = PW'(item.position);
  assign count_ext = PW'(count);
  assign rd_key    = rdata[ENTRY_W-1:VAL_W];

  // slot selection
  assign item_offs  = (item.mode == MODE_READ) ? AW'(item.position - POS_W'(1)) : '0;
  assign item_slot  = slot_add(head_idx, item_offs);
  assign scan_slot  = slot_add(head_idx, scan_idx[AW-1:0]);
  assign tail_slot  = slot_add(head_idx, count[AW-1:0]);
  assign scan_issue = cmd.scan_run && (scan_idx != count);

  // read port address mux
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = head_idx;
    if (scan_issue) begin
      rd_addr = scan_slot;
    end else if (cmd.rd_item) begin
      rd_addr = item_slot;
    end else if (!cmd.rd_head) begin
      rd_en = 1'b0;
    end
  end

  // entry storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_slot] <= {item.key, item.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
      count    <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      head_idx <= slot_add(head_idx, AW'(1));
      count    <= count - CW'(1);
    end
  end

  // duplicate key scan, each key is compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx    <= '0;
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx    <= '0;
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_pending <= scan_issue;
      if (scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmp_pending && rd_key == item.key) begin
        hit <= 1'b1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item             <= req;
      result.status    <= ST_OK;
      result.out_key   <= '0;
      result.out_value <= '0;
    end
    if (cmd.status_we) begin
      result.status <= cmd.status_code;
    end
    if (cmd.capture_result) begin
      result.out_key   <= rd_key;
      result.out_value <= rdata[VAL_W-1:0];
    end
    if (cmd.capture_head) begin
      result.entry_total <= count_ext[TOTAL_W-1:0];
      result.head_valid  <= (count != '0);
      result.head_key    <= (count != '0) ? rd_key : '0;
      result.head_value  <= (count != '0) ? rdata[VAL_W-1:0] : '0;
    end
  end

  assign rsp = result;

  // status back to the controller
  assign sts.mode      = item.mode;
  assign sts.full      = (count >= DEPTH_C);
  assign sts.empty     = (count == '0);
  assign sts.pos_bad   = (pos_ext == '0) || (pos_ext > count_ext);
  assign sts.scan_done = (scan_idx == count) && !cmp_pending;
  assign sts.scan_hit  = hit;

  `UKFQ_ASSERT(a_count_bound, count <= DEPTH_C, "entry count above depth")
  `UKFQ_ASSERT(a_no_push_full, !cmd.push || count != DEPTH_C, "push into a full queue")
  `UKFQ_ASSERT(a_no_pop_empty, !cmd.pop || count != '0, "pop from an empty queue")
  `UKFQ_ASSERT_NEXT(a_push_count, cmd.push, count == $past(count) + CW'(1), "push lost")

endmodule

@@ design/unique_key_fifo_queue_unit.sv @@
// Unique-key FIFO queue of key/value pairs, DEPTH entries in a circular store.
// Request channel req/req_valid/req_stall carries mode, key, value, position;
// a transfer happens when req_valid is high and req_stall is low.
// Response channel rsp/rsp_valid/rsp_stall gives one result per request:
// status, removed or read pair, entry count and the current head entry.
// One request is worked on at a time; req_stall stays high from the transfer
// until its result has been taken.
// Refused operations (full, empty, out of range) and the unused mode go from
// the operation state straight to the head read; remove and read first fetch
// the addressed entry, and an insert first scans the queue for its key: the
// duplicate check reads every queued key through the single memory read
// port, one key per cycle; a duplicate key ends the scan early.
// The next request is taken only after the result has been taken and the
// controller is back in idle, so requests never overlap.
// A stalled response holds rsp steady and blocks new requests until taken.
// Reset (rst, synchronous) empties the queue and returns to idle; the entry
// memory itself is not cleared, only data of occupied entries reaches rsp.
module unique_key_fifo_queue_unit
  import ukfq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ukfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ukfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
